[src/cpd_pkg.sv]
// shared types, widths and the crc-8 step for the packet deframer
// no dependencies
`default_nettype none

package cpd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned IDX_W  = 5;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  // completed frame handed from parser to readout
  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] seq;
    logic [BYTE_W-1:0] ptype;
    logic [LEN_W-1:0]  n;
  } frame_done_t;

  // one byte into a crc-8, msb first, no reflection
  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) c = (c << 1) ^ CRC_POLY;
      else c = c << 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/crc8_packet_deframer.sv]
// Start/length/CRC-8 packet deframer. Bytes enter on the in_ channel, one
// item per cycle while a frame is being parsed: the block waits for the
// start_marker byte, checks the length byte (2 to 2 + payload_limit, the limit
// saturating at MAX_PAYLOAD), writes the SEQ, TYPE and payload bytes into a
// single-port-write, single-port-read byte store while folding them into a
// CRC-8 (poly 0x31, init 0, msb first, no final xor), then compares the next
// byte with that CRC. A good frame produces one out_ item per payload byte, in
// order, with last on the final one; an empty payload gives one item with
// byte_index and payload_byte zero and last set. Bad lengths and CRC mismatches
// are dropped without any output. After a good CRC byte the input is held off
// (in_ready low) while the payload is read back, and longer while out_ready is
// low with a result waiting; the store gives one read per cycle, with registered
// read data. The output register lets the next frame's bytes be taken while
// the last result waits.
// Depends on cpd_pkg, cpd_store, cpd_parser, cpd_readout.
`default_nettype none

module crc8_packet_deframer
  import cpd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration writes
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [BYTE_W-1:0] cfg_wdata,
  // received bytes
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  // payload results
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [BYTE_W-1:0] out_seq_num,
  output logic      [BYTE_W-1:0] out_pkt_type,
  output logic      [LEN_W-1:0]  out_payload_len,
  output logic      [IDX_W-1:0]  out_byte_index,
  output logic      [BYTE_W-1:0] out_payload_byte,
  output logic                   out_last
);

  // store holds seq, type and up to MAX_PAYLOAD payload bytes
  localparam int unsigned DEPTH = MAX_PAYLOAD + 2;
  localparam int unsigned AW    = $clog2(DEPTH);
  // length byte counter range is 0 .. MAX_PAYLOAD + 2
  localparam int unsigned CW    = $clog2(MAX_PAYLOAD + 3);

  // register indexes
  localparam logic CFG_START_MARKER  = 1'b0;
  localparam logic CFG_PAYLOAD_LIMIT = 1'b1;

  logic [BYTE_W-1:0] start_marker_r;
  logic [LEN_W-1:0]  payload_limit_r;

  logic              in_acc;
  logic              ro_busy;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  frame_done_t       done;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r  <= 8'd170;
      payload_limit_r <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_MARKER:  start_marker_r  <= cfg_wdata;
        CFG_PAYLOAD_LIMIT: payload_limit_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input is held off only while a payload is being read out
  assign in_ready = !ro_busy;
  assign in_acc   = in_valid && in_ready;

  cpd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW),
    .CW          (CW)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (in_acc),
    .rx_byte       (in_rx_byte),
    .start_marker  (start_marker_r),
    .payload_limit (payload_limit_r),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .done          (done)
  );

  cpd_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cpd_readout #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_readout (
    .clk              (clk),
    .rst_n            (rst_n),
    .done             (done),
    .busy             (ro_busy),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_seq_num      (out_seq_num),
    .out_pkt_type     (out_pkt_type),
    .out_payload_len  (out_payload_len),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // the store is never written and read back in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("store written and read in the same cycle");

  // a good frame only completes while the readout is free
  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done.start |-> !ro_busy)
    else $error("frame completed during readout");

  // an empty packet is always a single, final item
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload_len == '0) |-> out_last)
    else $error("empty packet result without last");
`endif

endmodule

`default_nettype wire

[src/cpd_store.sv]
// frame byte store: one write port, one read port with registered data
// uses cpd_pkg
`default_nettype none

module cpd_store
  import cpd_pkg::*;
#(
  parameter int unsigned DEPTH = 34,
  parameter int unsigned AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[src/cpd_parser.sv]
// frame parser: start, length check, data capture into the store, crc check
// uses cpd_pkg
`default_nettype none

module cpd_parser
  import cpd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic [BYTE_W-1:0] start_marker,
  input  wire logic [LEN_W-1:0]  payload_limit,
  output logic                   wr_en,
  output logic      [AW-1:0]     wr_addr,
  output logic      [BYTE_W-1:0] wr_data,
  output frame_done_t            done
);

  typedef enum logic [1:0] {
    PH_START,
    PH_LEN,
    PH_DATA,
    PH_CRC
  } phase_t;

  localparam logic [LEN_W-1:0] LIM_MAX = LEN_W'(MAX_PAYLOAD);

  phase_t            phase_r, phase_nxt;
  logic [CW-1:0]     exp_r, exp_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic [BYTE_W-1:0] seq_r, type_r;
  logic [LEN_W-1:0]  eff_limit;
  logic              len_ok;
  logic [CW-1:0]     fill_inc;

  assign eff_limit = (payload_limit > LIM_MAX) ? LIM_MAX : payload_limit;
  assign len_ok    = (rx_byte >= 8'd2) &&
                     ((BYTE_W+1)'(rx_byte) <= (BYTE_W+1)'(eff_limit) + (BYTE_W+1)'(2));
  assign fill_inc  = fill_r + CW'(1);

  always_comb begin
    phase_nxt = phase_r;
    exp_nxt   = exp_r;
    fill_nxt  = fill_r;
    crc_nxt   = crc_r;
    if (acc) begin
      case (phase_r)
        PH_START: if (rx_byte == start_marker) phase_nxt = PH_LEN;
        PH_LEN: begin
          if (len_ok) begin
            exp_nxt   = CW'(rx_byte);
            fill_nxt  = '0;
            crc_nxt   = CRC_INIT;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_START;
          end
        end
        PH_DATA: begin
          fill_nxt = fill_inc;
          crc_nxt  = crc8_step(crc_r, rx_byte);
          if (fill_inc >= exp_r) phase_nxt = PH_CRC;
        end
        PH_CRC:  phase_nxt = PH_START;
        default: phase_nxt = PH_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      exp_r   <= '0;
      fill_r  <= '0;
      crc_r   <= CRC_INIT;
    end else begin
      phase_r <= phase_nxt;
      exp_r   <= exp_nxt;
      fill_r  <= fill_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // header bytes are also kept in flops for the readout
  always_ff @(posedge clk) begin
    if (acc && phase_r == PH_DATA && fill_r == CW'(0)) seq_r  <= rx_byte;
    if (acc && phase_r == PH_DATA && fill_r == CW'(1)) type_r <= rx_byte;
  end

  assign wr_en   = acc && (phase_r == PH_DATA);
  assign wr_addr = fill_r[AW-1:0];
  assign wr_data = rx_byte;

  assign done.start = acc && (phase_r == PH_CRC) && (rx_byte == crc_r);
  assign done.seq   = seq_r;
  assign done.ptype = type_r;
  assign done.n     = LEN_W'(exp_r - CW'(2));

endmodule

`default_nettype wire

[src/cpd_readout.sv]
// result sequencer: reads payload bytes from the store into the output register
// uses cpd_pkg
`default_nettype none

module cpd_readout
  import cpd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned AW = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  frame_done_t            done,
  output logic                   busy,
  output logic                   rd_en,
  output logic      [AW-1:0]     rd_addr,
  input  wire logic [BYTE_W-1:0] rd_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [BYTE_W-1:0] out_seq_num,
  output logic      [BYTE_W-1:0] out_pkt_type,
  output logic      [LEN_W-1:0]  out_payload_len,
  output logic      [IDX_W-1:0]  out_byte_index,
  output logic      [BYTE_W-1:0] out_payload_byte,
  output logic                   out_last
);

  localparam int unsigned KW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [1:0] {
    RO_IDLE,
    RO_EMPTY,
    RO_LOAD
  } ro_state_t;

  ro_state_t         state_r;
  logic [KW-1:0]     k_r;
  logic [KW-1:0]     k_inc;
  logic [BYTE_W-1:0] seq_r, type_r;
  logic [LEN_W-1:0]  n_r;
  logic              out_valid_r;
  logic              can_load;
  logic              is_last;
  logic              load;

  assign can_load = !out_valid_r || out_ready;
  assign k_inc    = k_r + KW'(1);
  assign is_last  = (LEN_W'(k_inc) == n_r);
  assign busy     = (state_r != RO_IDLE);
  // a new item enters the output register this cycle
  assign load     = can_load && (state_r inside {RO_EMPTY, RO_LOAD});

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(2);
    case (state_r)
      RO_IDLE: begin
        rd_en   = done.start && (done.n != '0);
        rd_addr = AW'(2);
      end
      RO_LOAD: begin
        rd_en   = can_load && !is_last;
        rd_addr = AW'(k_inc) + AW'(2);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = AW'(2);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= RO_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        RO_IDLE: begin
          if (done.start) begin
            seq_r   <= done.seq;
            type_r  <= done.ptype;
            n_r     <= done.n;
            k_r     <= '0;
            state_r <= (done.n == '0) ? RO_EMPTY : RO_LOAD;
          end
        end
        RO_EMPTY: begin
          if (can_load) begin
            out_seq_num      <= seq_r;
            out_pkt_type     <= type_r;
            out_payload_len  <= '0;
            out_byte_index   <= '0;
            out_payload_byte <= '0;
            out_last         <= 1'b1;
            state_r          <= RO_IDLE;
          end
        end
        RO_LOAD: begin
          if (can_load) begin
            out_seq_num      <= seq_r;
            out_pkt_type     <= type_r;
            out_payload_len  <= n_r;
            out_byte_index   <= IDX_W'(k_r);
            out_payload_byte <= rd_data;
            out_last         <= is_last;
            k_r              <= k_inc;
            if (is_last) state_r <= RO_IDLE;
          end
        end
        default: state_r <= RO_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[bench/crc8_packet_deframer_tb.sv]
// self-checking bench for crc8_packet_deframer: builds framed byte streams,
// predicts the payload items in-bench and checks every output item in order
// depends on cpd_pkg and the deframer rtl
`default_nettype none

module crc8_packet_deframer_tb
  import cpd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PAYLOAD   = 32;
  localparam int unsigned STORE_DEPTH   = MAX_PAYLOAD + 2;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned IDLE_PCT      = 32;
  localparam logic [7:0]  POLY          = 8'h31;

  // register indexes on the config port
  localparam logic REG_START_MARKER  = 1'b0;
  localparam logic REG_PAYLOAD_LIMIT = 1'b1;

  typedef enum logic [1:0] {HUNT, GET_LEN, GET_DATA, GET_CRC} rx_phase_t;

  // one expected output item
  typedef struct {
    logic [BYTE_W-1:0] seq;
    logic [BYTE_W-1:0] ptype;
    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic              last;
  } payload_beat_t;

  // clock, reset and dut inputs, all known from time zero
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic              cfg_index  = 1'b0;
  logic [BYTE_W-1:0] cfg_wdata  = '0;
  logic              in_valid   = 1'b0;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_ready  = 1'b0;

  wire logic              in_ready;
  wire logic              out_valid;
  wire logic [BYTE_W-1:0] out_seq_num;
  wire logic [BYTE_W-1:0] out_pkt_type;
  wire logic [LEN_W-1:0]  out_payload_len;
  wire logic [IDX_W-1:0]  out_byte_index;
  wire logic [BYTE_W-1:0] out_payload_byte;
  wire logic              out_last;

  // bench control
  logic              steady   = 1'b0;   // no random idling on either side
  logic              hold_go  = 1'b0;   // starts a long receiver hold-off
  int unsigned       hold_left = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       errors    = 0;
  int unsigned       bytes_queued = 0;

  logic [BYTE_W-1:0] rx_backlog [$];    // bytes waiting for the driver
  payload_beat_t     beats_due  [$];    // predicted output items, oldest first
  logic [BYTE_W-1:0] pay_buf [0:MAX_PAYLOAD-1];

  // mirrored configuration and parser state
  logic [BYTE_W-1:0] cfg_marker;
  logic [LEN_W-1:0]  cfg_limit;
  rx_phase_t         pr_phase;
  logic [LEN_W-1:0]  pr_count;
  int unsigned       pr_fill;
  logic [BYTE_W-1:0] pr_store [0:STORE_DEPTH-1];
  logic [BYTE_W-1:0] pr_crc;

  always #1 clk = ~clk;

  crc8_packet_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_seq_num      (out_seq_num),
    .out_pkt_type     (out_pkt_type),
    .out_payload_len  (out_payload_len),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last)
  );

  // bit-serial crc-8, msb first
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ d[i];
      c  = {c[6:0], 1'b0};
      if (fb) c = c ^ POLY;
    end
    return c;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0d] error: %s", cycle_cnt, msg);
    errors++;
  endtask

  // advance the mirrored parser by one accepted byte, queue any output items
  task automatic track_rx_byte(input logic [7:0] b);
    int unsigned   lim;
    int unsigned   n;
    payload_beat_t beat;
    lim = (cfg_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_limit;
    case (pr_phase)
      HUNT: begin
        if (b == cfg_marker) pr_phase = GET_LEN;
      end
      GET_LEN: begin
        // a bad length byte goes back to hunting and is not looked at again
        if (b < 2 || b > 2 + lim) begin
          pr_phase = HUNT;
        end else begin
          pr_count = b[LEN_W-1:0];
          pr_fill  = 0;
          pr_crc   = 8'h00;
          pr_phase = GET_DATA;
        end
      end
      GET_DATA: begin
        if (pr_fill < STORE_DEPTH) pr_store[pr_fill] = b;
        pr_fill++;
        pr_crc = crc8_fold(pr_crc, b);
        if (pr_fill >= pr_count) pr_phase = GET_CRC;
      end
      default: begin
        pr_phase = HUNT;
        // crc mismatch drops the frame without output
        if (b == pr_crc) begin
          n = pr_count - 2;
          beat.seq   = pr_store[0];
          beat.ptype = pr_store[1];
          beat.len   = n[LEN_W-1:0];
          if (n == 0) begin
            // empty payload: one marker item
            beat.idx  = '0;
            beat.data = '0;
            beat.last = 1'b1;
            beats_due.push_back(beat);
          end else begin
            for (int unsigned k = 0; k < n; k++) begin
              beat.idx  = k[IDX_W-1:0];
              beat.data = pr_store[2 + k];
              beat.last = (k + 1 == n);
              beats_due.push_back(beat);
            end
          end
        end
      end
    endcase
  endtask

  // driver: hold an offered item until taken, otherwise maybe offer the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_rx_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (rx_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here so the sender keeps offering meanwhile
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor: random ready, compare each taken item with the oldest prediction
  always @(posedge clk) begin
    payload_beat_t beat;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && !hold_go &&
                   (steady || $urandom_range(99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        if (beats_due.size() == 0) begin
          report_error($sformatf("item with nothing expected (seq %0h idx %0d)",
                                 out_seq_num, out_byte_index));
        end else begin
          beat = beats_due.pop_front();
          if (out_seq_num !== beat.seq)
            report_error($sformatf("seq_num %0h, expected %0h", out_seq_num, beat.seq));
          if (out_pkt_type !== beat.ptype)
            report_error($sformatf("pkt_type %0h, expected %0h", out_pkt_type, beat.ptype));
          if (out_payload_len !== beat.len)
            report_error($sformatf("payload_len %0d, expected %0d",
                                   out_payload_len, beat.len));
          if (out_byte_index !== beat.idx)
            report_error($sformatf("byte_index %0d, expected %0d", out_byte_index, beat.idx));
          if (out_payload_byte !== beat.data)
            report_error($sformatf("payload_byte %0h, expected %0h",
                                   out_payload_byte, beat.data));
          if (out_last !== beat.last)
            report_error($sformatf("last %0b, expected %0b", out_last, beat.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_rx(input logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_queued++;
  endtask

  // one register write; the mirror changes at the edge that takes it
  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_MARKER) cfg_marker = val;
    else cfg_limit = val[LEN_W-1:0];
  endtask

  // full frame from pay_buf[0..n-1], crc optionally corrupted
  task automatic queue_frame(input logic [7:0] seq, input logic [7:0] ptype,
                             input int unsigned n, input bit bad_crc);
    logic [7:0] c;
    c = 8'h00;
    push_rx(cfg_marker);
    push_rx(8'(n + 2));
    push_rx(seq);
    c = crc8_fold(c, seq);
    push_rx(ptype);
    c = crc8_fold(c, ptype);
    for (int unsigned k = 0; k < n; k++) begin
      push_rx(pay_buf[k]);
      c = crc8_fold(c, pay_buf[k]);
    end
    if (bad_crc) c = c ^ 8'($urandom_range(1, 255));
    push_rx(c);
  endtask

  // mostly good frames with random content, plus corrupt frames, bad lengths, noise
  task automatic queue_random_traffic(input int unsigned budget);
    int unsigned first;
    int unsigned lim;
    int unsigned n;
    int unsigned pick;
    first = bytes_queued;
    lim = (cfg_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_limit;
    while (bytes_queued - first < budget) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        // mostly short payloads, now and then up to the limit
        if (lim == 0) n = 0;
        else if ($urandom_range(99) < 85) n = $urandom_range(lim < 6 ? lim : 6, 0);
        else n = $urandom_range(lim, 0);
        for (int unsigned k = 0; k < n; k++) pay_buf[k] = 8'($urandom_range(255));
        queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), n, pick >= 70);
      end else if (pick < 88) begin
        push_rx(cfg_marker);
        if ($urandom_range(1) == 0) push_rx(8'($urandom_range(1)));
        else push_rx(8'($urandom_range(255, lim + 3)));
      end else begin
        repeat ($urandom_range(4, 1)) push_rx(8'($urandom_range(255)));
      end
    end
  endtask

  // wait until every byte is taken and every predicted item has arrived
  task automatic drain;
    while (rx_backlog.size() != 0 || in_valid || beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    cfg_marker = 8'd170;
    cfg_limit  = 6'd32;
    pr_phase   = HUNT;
    pr_count   = '0;
    pr_fill    = 0;
    pr_crc     = 8'h00;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default setting written back explicitly
    write_reg(REG_START_MARKER, 8'hAA);
    write_reg(REG_PAYLOAD_LIMIT, 8'd32);

    // directed: empty payload with extreme seq/type
    queue_frame(8'h00, 8'hFF, 0, 1'b0);
    // lengths below two and above the limit
    push_rx(cfg_marker);
    push_rx(8'd0);
    push_rx(cfg_marker);
    push_rx(8'd1);
    push_rx(cfg_marker);
    push_rx(8'd35);
    // bad length equal to the start byte must not restart the frame
    push_rx(cfg_marker);
    push_rx(cfg_marker);
    push_rx(8'd2);
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(crc8_fold(crc8_fold(8'h00, 8'h00), 8'hFF));
    // crc mismatch is dropped
    pay_buf[0] = 8'h5A;
    queue_frame(8'h11, 8'h22, 1, 1'b1);
    // payload extremes
    pay_buf[0] = 8'h00;
    pay_buf[1] = 8'hFF;
    queue_frame(8'hFF, 8'h00, 2, 1'b0);

    queue_random_traffic(80);
    drain;

    // zero marker, zero limit: only empty payloads pass
    write_reg(REG_START_MARKER, 8'h00);
    write_reg(REG_PAYLOAD_LIMIT, 8'd0);
    queue_random_traffic(40);
    drain;

    // all-ones marker, limit above the parameter saturates; no idling here
    steady <= 1'b1;
    write_reg(REG_START_MARKER, 8'hFF);
    write_reg(REG_PAYLOAD_LIMIT, 8'd63);
    for (int k = 0; k < MAX_PAYLOAD; k++) pay_buf[k] = 8'($urandom_range(255));
    queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), MAX_PAYLOAD, 1'b0);
    queue_random_traffic(60);
    drain;
    steady <= 1'b0;

    // random setting, receiver stalls long while bytes keep coming
    write_reg(REG_START_MARKER, 8'($urandom_range(255)));
    write_reg(REG_PAYLOAD_LIMIT, 8'($urandom_range(MAX_PAYLOAD, 1)));
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    queue_random_traffic(100);
    drain;

    if (beats_due.size() != 0)
      report_error($sformatf("%0d expected items never came", beats_due.size()));

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
